### src/plt_pkg.sv
// Shared types and constants for the page last-access tracker.
// Holds the stream beat layout and the result status codes.
// No dependencies.
package plt_pkg;

  // Input tdata layout, lowest bit first: start address, byte_length, submission, read_page
  localparam int StartLsb   = 0;
  localparam int LengthLsb  = 32;
  localparam int SubLsb     = 64;
  localparam int RpageLsb   = 128;
  localparam int InDataBits = 152;  // 148 bits of fields, padded to whole bytes

  localparam int SubBits    = 64;
  localparam int RpageBits  = 20;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    StUpdated = 2'd0,
    StIgnored = 2'd1,
    StSkipped = 2'd2,
    StRead    = 2'd3
  } status_e;

  // Input tuser values
  localparam logic OpMark = 1'b0;
  localparam logic OpRead = 1'b1;

endpackage

### src/plt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the per-page submission table. No dependencies.
module plt_ram #(
  parameter int Width = 64,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### src/page_last_access_tracker.sv
// Page last-access tracker: one 64-bit entry per page of a buffer of 2^ADDR_BITS bytes
// (pages of 2^PAGE_SHIFT bytes), each holding the highest submission that touched the page.
// A mark beat (tuser 0) raises every page of its byte range to its submission; a read beat
// (tuser 1) returns one page entry, all ones past the table. Every input beat gives exactly
// one output beat. After reset the block sweeps zeros through the table, one entry per cycle,
// with s_axis_tready low. Items are handled one at a time: a read passes through the prep,
// read-wait and done states, an ignored or span-cache skipped mark through prep and done, and
// an updating mark through prep, a walk of every page in its span, and done; the walk is paced
// by the table RAM's single read-modify-write per cycle. A new item is taken while a result
// waits on the output. Depends on plt_pkg and plt_ram.
module page_last_access_tracker #(
  parameter int ADDR_BITS  = 24,
  parameter int PAGE_SHIFT = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] start address, [63:32] byte_length, [127:64] submission, [147:128] read_page
  input  logic [plt_pkg::InDataBits-1:0] s_axis_tdata,
  input  logic         s_axis_tuser,   // [0] op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // [63:0] page_submission
  output logic [1:0]   m_axis_tuser    // [1:0] status
);

  localparam int          PageBits = ADDR_BITS - PAGE_SHIFT;
  localparam logic [32:0] BufSize  = 33'(1) << ADDR_BITS;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_RDWAIT,
    ST_WALK,
    ST_DONE
  } state_e;

  state_e state_q;

  // accepted item
  logic                           op_q;
  logic [31:0]                    start_q;
  logic [32:0]                    end_q;
  logic [plt_pkg::SubBits-1:0]    sub_q;
  logic [plt_pkg::RpageBits-1:0]  rpage_q;
  logic                           invalid_q;

  // span cache
  logic [plt_pkg::SubBits-1:0]    cache_sub_q;
  logic [PageBits-1:0]            cache_first_q;
  logic [PageBits-1:0]            cache_last_q;

  // walk / clear pointer and span end
  logic [PageBits-1:0]            page_q;
  logic [PageBits-1:0]            last_q;

  // pending result and output register
  plt_pkg::status_e               res_status_q;
  logic [plt_pkg::SubBits-1:0]    res_data_q;
  logic                           out_valid_q;
  plt_pkg::status_e               out_status_q;
  logic [plt_pkg::SubBits-1:0]    out_data_q;

  // input beat fields
  logic [31:0]                    in_start;
  logic [31:0]                    in_len;
  logic [plt_pkg::SubBits-1:0]    in_sub;
  logic [plt_pkg::RpageBits-1:0]  in_rpage;
  logic [32:0]                    in_end_full;
  logic [32:0]                    in_end;
  logic                           in_fire;

  assign in_start    = s_axis_tdata[plt_pkg::StartLsb +: 32];
  assign in_len      = s_axis_tdata[plt_pkg::LengthLsb +: 32];
  assign in_sub      = s_axis_tdata[plt_pkg::SubLsb +: plt_pkg::SubBits];
  assign in_rpage    = s_axis_tdata[plt_pkg::RpageLsb +: plt_pkg::RpageBits];
  assign in_end_full = 33'(in_start) + 33'(in_len);
  assign in_end      = (in_end_full > BufSize) ? BufSize : in_end_full;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // span and cache check of the held mark
  logic [32:0]         end_m1;
  logic [PageBits-1:0] first_pg;
  logic [PageBits-1:0] last_pg;
  logic                cache_hit;

  assign end_m1    = end_q - 33'd1;
  assign first_pg  = start_q[PAGE_SHIFT +: PageBits];
  assign last_pg   = end_m1[PAGE_SHIFT +: PageBits];
  assign cache_hit = (sub_q == cache_sub_q) && (first_pg >= cache_first_q)
                     && (last_pg <= cache_last_q);

  // read page index and past-the-table check
  logic [31:0]         rp_ext;
  logic                rp_past;
  logic [PageBits-1:0] rp_idx;

  assign rp_ext  = 32'(rpage_q);
  assign rp_past = (rp_ext >> PageBits) != 32'd0;
  assign rp_idx  = rp_ext[PageBits-1:0];

  // table RAM ports
  logic                        ram_we;
  logic [PageBits-1:0]         ram_waddr;
  logic [plt_pkg::SubBits-1:0] ram_wdata;
  logic [PageBits-1:0]         ram_raddr;
  logic [plt_pkg::SubBits-1:0] ram_rdata;
  logic [plt_pkg::SubBits-1:0] walk_max;

  assign walk_max = (ram_rdata < sub_q) ? sub_q : ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = page_q;
    ram_wdata = '0;
    ram_raddr = page_q;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_PREP: begin
        ram_raddr = (op_q == plt_pkg::OpRead) ? rp_idx : first_pg;
      end
      ST_WALK: begin
        // write back this page while the next one is read
        ram_we    = 1'b1;
        ram_wdata = walk_max;
        ram_raddr = page_q + PageBits'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  plt_ram #(
    .Width(plt_pkg::SubBits),
    .Depth(2 ** PageBits)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // sequencer: state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      page_q        <= '0;
      last_q        <= '0;
      op_q          <= plt_pkg::OpMark;
      start_q       <= '0;
      end_q         <= '0;
      sub_q         <= '0;
      rpage_q       <= '0;
      invalid_q     <= 1'b0;
      cache_sub_q   <= '0;
      cache_first_q <= PageBits'(1);
      cache_last_q  <= '0;
      res_status_q  <= plt_pkg::StUpdated;
      res_data_q    <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= plt_pkg::StUpdated;
      out_data_q    <= '0;
    end else begin
      // output register: load the pending result, or drop an accepted beat
      if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_data_q   <= res_data_q;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          page_q <= page_q + PageBits'(1);
          if (page_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            op_q      <= s_axis_tuser;
            start_q   <= in_start;
            end_q     <= in_end;
            sub_q     <= in_sub;
            rpage_q   <= in_rpage;
            invalid_q <= (in_len == 32'd0) || (in_sub == '0) || (33'(in_start) >= BufSize);
            state_q   <= ST_PREP;
          end
        end
        ST_PREP: begin
          res_data_q <= '0;
          if (op_q == plt_pkg::OpRead) begin
            state_q <= ST_RDWAIT;
          end else if (invalid_q) begin
            res_status_q <= plt_pkg::StIgnored;
            state_q      <= ST_DONE;
          end else if (cache_hit) begin
            res_status_q <= plt_pkg::StSkipped;
            state_q      <= ST_DONE;
          end else begin
            cache_sub_q   <= sub_q;
            cache_first_q <= first_pg;
            cache_last_q  <= last_pg;
            page_q        <= first_pg;
            last_q        <= last_pg;
            state_q       <= ST_WALK;
          end
        end
        ST_RDWAIT: begin
          res_status_q <= plt_pkg::StRead;
          res_data_q   <= rp_past ? '1 : ram_rdata;
          state_q      <= ST_DONE;
        end
        ST_WALK: begin
          page_q <= page_q + PageBits'(1);
          if (page_q == last_q) begin
            res_status_q <= plt_pkg::StUpdated;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          // the result moves to the output register once it is free
          if (!out_valid_q || m_axis_tready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = out_data_q;

  // walk never runs past the end of its span
  a_walk_in_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> page_q <= last_q)
    else $error("walk pointer past span end");

  // a walk write never lowers an entry below the item's submission
  a_walk_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WALK |-> ram_we && ram_wdata >= sub_q)
    else $error("walk write below submission");

  // only read results carry data
  a_mark_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != plt_pkg::StRead |-> m_axis_tdata == '0)
    else $error("mark result with nonzero data");

  // a pending result waits while the output beat is stalled
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && out_valid_q && !m_axis_tready |=> state_q == ST_DONE)
    else $error("result overwrote a stalled output beat");

  // no input beat is taken during the clearing sweep
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLEAR |-> !s_axis_tready && ram_we)
    else $error("input accepted during table clear");

endmodule

### verif/testbench.sv
// Self-checking testbench for page_last_access_tracker: directed beats, then random traffic.
// Results are predicted by an in-bench model of the page table and span cache.
// Depends on plt_pkg and the page_last_access_tracker RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          AddrBits   = 24;
  localparam int          PageShift  = 12;
  localparam int          PageCount  = 1 << (AddrBits - PageShift);
  localparam int unsigned BufBytes   = 1 << AddrBits;
  localparam int unsigned PageBytes  = 1 << PageShift;
  localparam int          NumRandom  = 1000;
  localparam int          NumDirRows = 22;
  localparam int          DrainWait  = 20;
  // worst case: every beat a full-buffer mark plus the longest gap and stall
  localparam int          CycleLimit =
      PageCount + (NumDirRows + NumRandom) * (PageCount + 30) * 3;

  // one input item
  typedef struct packed {
    logic        op;
    logic [31:0] start;
    logic [31:0] length;
    logic [63:0] sub;
    logic [19:0] rpage;
  } access_t;

  // one result beat
  typedef struct packed {
    plt_pkg::status_e status;
    logic [63:0]      page_sub;
  } report_t;

  // directed row: item, plus a hand-written result where typed is set
  typedef struct packed {
    logic             op;
    logic [31:0]      start;
    logic [31:0]      length;
    logic [63:0]      sub;
    logic [19:0]      rpage;
    logic             typed;
    plt_pkg::status_e status;
    logic [63:0]      page_sub;
  } dir_row_t;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam dir_row_t DirRows[NumDirRows] = '{
    // freshly cleared table, reads inside and past it
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd0,    1'b1, plt_pkg::StRead, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd4095, 1'b1, plt_pkg::StRead, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd4096, 1'b1, plt_pkg::StRead, AllOnes},
    '{plt_pkg::OpRead, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AllOnes, 20'hFFFFF,
      1'b1, plt_pkg::StRead, AllOnes},
    // invalid marks: zero length, zero submission, start past the buffer
    '{plt_pkg::OpMark, 32'h100, 32'h0, 64'd5, 20'd0, 1'b1, plt_pkg::StIgnored, 64'h0},
    '{plt_pkg::OpMark, 32'h100, 32'h10, 64'h0, 20'd0, 1'b1, plt_pkg::StIgnored, 64'h0},
    '{plt_pkg::OpMark, 32'h0100_0000, 32'h1, 64'd5, 20'd0,
      1'b1, plt_pkg::StIgnored, 64'h0},
    '{plt_pkg::OpMark, 32'hFFFF_FFFF, 32'hFFFF_FFFF, AllOnes, 20'hFFFFF,
      1'b1, plt_pkg::StIgnored, 64'h0},
    // first update, then the same span hits the cache
    '{plt_pkg::OpMark, 32'h0, 32'h1, 64'd5, 20'd0, 1'b1, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpMark, 32'h0, 32'h1, 64'd5, 20'd0, 1'b1, plt_pkg::StSkipped, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd0, 1'b1, plt_pkg::StRead, 64'd5},
    // range running past the buffer end is clamped to the last page
    '{plt_pkg::OpMark, 32'h00FF_FFFF, 32'hFFFF_FFFF, 64'd7, 20'd0,
      1'b1, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd4095, 1'b1, plt_pkg::StRead, 64'd7},
    // multi-page span, sub-span repeat, lower submission over it
    '{plt_pkg::OpMark, 32'h1000, 32'h3000, 64'd9, 20'd0, 1'b0, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpMark, 32'h2000, 32'h1000, 64'd9, 20'd0, 1'b0, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpMark, 32'h1000, 32'h3000, 64'd3, 20'd0, 1'b0, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd2, 1'b0, plt_pkg::StUpdated, 64'h0},
    // whole buffer at the largest submission
    '{plt_pkg::OpMark, 32'h0, 32'h0100_0000, AllOnes, 20'd0,
      1'b0, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd100, 1'b1, plt_pkg::StRead, AllOnes},
    '{plt_pkg::OpMark, 32'h0, 32'hFFFF_FFFF, AllOnes, 20'd0,
      1'b0, plt_pkg::StUpdated, 64'h0},
    // two bytes straddling a page boundary
    '{plt_pkg::OpMark, 32'h3FFF, 32'h2, 64'h8000_0000_0000_0000, 20'd0,
      1'b0, plt_pkg::StUpdated, 64'h0},
    '{plt_pkg::OpRead, 32'h0, 32'h0, 64'h0, 20'd4, 1'b0, plt_pkg::StUpdated, 64'h0}
  };

  logic         clk_i;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [151:0] s_axis_tdata  = '0;
  logic         s_axis_tuser  = plt_pkg::OpMark;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  page_last_access_tracker #(
    .ADDR_BITS (AddrBits),
    .PAGE_SHIFT(PageShift)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // predicted tracker state
  logic [63:0] page_sub_table [PageCount];
  logic [63:0] span_sub;
  logic [11:0] span_first;
  logic [11:0] span_last;
  logic [63:0] sub_counter;

  report_t     expected_reports[$];
  report_t     oldest_report;
  int          error_count   = 0;
  int          cycle_count   = 0;
  int          gap_pct       = 0;
  int          stall_pct     = 0;
  int          stall_left    = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Tracker model: returns the result of one item and updates the table.
  function automatic report_t predict_access(input access_t it);
    report_t     rep;
    logic [32:0] end_byte;
    logic [31:0] first_pg;
    logic [31:0] last_pg;
    rep.status   = plt_pkg::StUpdated;
    rep.page_sub = '0;
    if (it.op == plt_pkg::OpRead) begin
      rep.status   = plt_pkg::StRead;
      rep.page_sub = (it.rpage < PageCount) ? page_sub_table[it.rpage] : AllOnes;
      return rep;
    end
    if (it.length == 0 || it.sub == 0 || it.start >= BufBytes) begin
      rep.status = plt_pkg::StIgnored;
      return rep;
    end
    end_byte = {1'b0, it.start} + {1'b0, it.length};
    if (end_byte > {1'b0, BufBytes}) end_byte = {1'b0, BufBytes};
    first_pg = it.start >> PageShift;
    last_pg  = 32'((end_byte - 33'd1) >> PageShift);
    if (last_pg > PageCount - 1) last_pg = PageCount - 1;
    if (first_pg > last_pg) first_pg = last_pg;
    // span cache hit: same submission, span inside the cached one
    if (it.sub == span_sub && first_pg >= span_first && last_pg <= span_last) begin
      rep.status = plt_pkg::StSkipped;
      return rep;
    end
    for (int p = first_pg; p <= last_pg; p++) begin
      if (page_sub_table[p] < it.sub) page_sub_table[p] = it.sub;
    end
    span_sub   = it.sub;
    span_first = first_pg[11:0];
    span_last  = last_pg[11:0];
    return rep;
  endfunction

  // Present one beat, hold it until accepted, then queue its expected result.
  task automatic send_access(input access_t it, input logic typed, input report_t typed_rep);
    logic    took;
    report_t rep;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    // read_page, submission, byte_length, start address from the top down
    s_axis_tdata  <= {4'b0, it.rpage, it.sub, it.length, it.start};
    do begin
      @(posedge clk_i);
      took = s_axis_tready;
      @(negedge clk_i);
    end while (!took);
    rep = predict_access(it);
    expected_reports.insert(expected_reports.size(), typed ? typed_rep : rep);
  endtask

  // Hold the sender until every queued result has come back.
  task automatic drain_reports();
    s_axis_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk_i);
  endtask

  // Random item: mostly well-formed marks and reads, some cache repeats and noise.
  function automatic access_t make_access();
    access_t     it;
    int unsigned kind;
    int unsigned p1;
    int unsigned p2;
    int unsigned end_b;
    it.op     = plt_pkg::OpMark;
    it.start  = $urandom();
    it.length = $urandom();
    it.sub    = {$urandom(), $urandom()};
    it.rpage  = 20'($urandom());
    kind      = $urandom_range(0, 99);
    if (kind < 20) begin
      it.op = plt_pkg::OpRead;
      if ($urandom_range(0, 3) != 0) it.rpage = 20'($urandom_range(0, PageCount - 1));
    end else if (kind < 30) begin
      // broken mark
      it.start  = $urandom_range(0, BufBytes - 1);
      it.length = $urandom_range(1, 3 * PageBytes);
      it.sub    = sub_counter;
      case ($urandom_range(0, 2))
        0:       it.length = '0;
        1:       it.sub    = '0;
        default: it.start  = $urandom_range(BufBytes, 32'hFFFF_FFFF);
      endcase
    end else if (kind < 45 && span_first <= span_last) begin
      // repeat inside the cached span, now and then one page wider
      p1 = $urandom_range(span_first, span_last);
      p2 = $urandom_range(span_first, span_last);
      it.start = (p1 << PageShift) | $urandom_range(0, PageBytes - 1);
      end_b    = (p2 << PageShift) | $urandom_range(0, PageBytes - 1);
      if (end_b < it.start) begin
        it.length = it.start - end_b + 1;
        it.start  = end_b;
      end else begin
        it.length = end_b - it.start + 1;
      end
      if ($urandom_range(0, 3) == 0) it.length = it.length + PageBytes;
      it.sub = span_sub;
    end else begin
      it.start = $urandom_range(0, BufBytes - 1);
      case ($urandom_range(0, 39))
        0: ;  // full 32-bit length, clamped at the buffer end
        1, 2: begin
          it.start  = BufBytes - $urandom_range(1, 3 * PageBytes);
          it.length = $urandom_range(1, 4 * PageBytes);
        end
        default: it.length = $urandom_range(1, 3 * PageBytes);
      endcase
      case ($urandom_range(0, 19))
        0: ;  // full 64-bit submission
        1, 2: it.sub = sub_counter - $urandom_range(0, 20);
        default: begin
          sub_counter = sub_counter + $urandom_range(0, 2);
          it.sub      = sub_counter;
        end
      endcase
    end
    return it;
  endfunction

  // Receiver stalls in random bursts
  always @(negedge clk_i) begin
    if (stall_left > 0 && stall_pct > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(0, 9);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result check against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_reports.size() == 0) begin
        $error("result beat with nothing expected: status %0d page_submission %h",
               m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        oldest_report = expected_reports.pop_front();
        if (m_axis_tuser !== oldest_report.status) begin
          $error("status mismatch: expected %0d, actual %0d",
                 oldest_report.status, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata !== oldest_report.page_sub) begin
          $error("page_submission mismatch: expected %h, actual %h",
                 oldest_report.page_sub, m_axis_tdata);
          error_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    access_t it;
    report_t rep;
    for (int p = 0; p < PageCount; p++) page_sub_table[p] = '0;
    span_sub    = '0;
    span_first  = 12'd1;
    span_last   = 12'd0;
    sub_counter = 64'd1;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed rows
    gap_pct   = 25;
    stall_pct = 25;
    foreach (DirRows[i]) begin
      it  = '{DirRows[i].op, DirRows[i].start, DirRows[i].length,
              DirRows[i].sub, DirRows[i].rpage};
      rep = '{DirRows[i].status, DirRows[i].page_sub};
      send_access(it, DirRows[i].typed, rep);
    end
    drain_reports();

    // random traffic in phases; the last phase runs without gaps or stalls
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) begin
        if (n >= NumRandom - 100 || $urandom_range(0, 3) == 0) begin
          gap_pct   = 0;
          stall_pct = 0;
        end else begin
          gap_pct   = $urandom_range(10, 50);
          stall_pct = $urandom_range(10, 50);
        end
      end
      if (n < NumRandom - 100 && $urandom_range(0, 99) == 0) drain_reports();
      send_access(make_access(), 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (expected_reports.size() != 0) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

### page_last_access_tracker.f
src/plt_pkg.sv
src/plt_ram.sv
src/page_last_access_tracker.sv
verif/testbench.sv
